// ===== rtl/core/deqr_pkg.sv =====
// ============================================================================
// deqr_pkg: shared types for the ring double-ended queue
// Command codes, transaction payload structs and the cell operation codes
// used between the top level and the storage cells.
// ============================================================================
package deqr_pkg;

  // Command carried by each input transaction.
  typedef enum logic [1:0] {
    CMD_PUSH_R = 2'd0,
    CMD_POP_L  = 2'd1,
    CMD_POP_R  = 2'd2,
    CMD_QUERY  = 2'd3
  } deqr_cmd_t;

  // Operation applied to one storage cell in a cycle.
  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_LOAD       = 2'd1,
    CELL_TAKE_LEFT  = 2'd2,
    CELL_TAKE_RIGHT = 2'd3
  } deqr_cell_op_t;

  // Input transaction payload.
  typedef struct packed {
    deqr_cmd_t   command;
    logic [31:0] item_in;
  } deqr_req_t;

  // Result transaction payload.
  typedef struct packed {
    logic [31:0] item_out;
    logic [31:0] left_item;
    logic [31:0] right_item;
    logic [4:0]  count;
    logic        empty_res;
    logic        full_res;
    logic        error;
  } deqr_rsp_t;

endpackage

// ===== rtl/core/deqr_cell.sv =====
// ============================================================================
// deqr_cell: one storage cell of the queue chain
// Holds one item and each cycle either keeps it, loads a new item, or takes
// the item of its left or right neighbor.
// ============================================================================
module deqr_cell import deqr_pkg::*; #(
  parameter int W = 32
) (
  input  logic          clk,
  input  deqr_cell_op_t op,
  input  logic [W-1:0]  load_data,
  input  logic [W-1:0]  from_left,
  input  logic [W-1:0]  from_right,
  output logic [W-1:0]  q,
  output logic [W-1:0]  d
);

  // Select the value the cell holds after this cycle.
  always_comb begin
    unique case (op)
      CELL_HOLD:       d = q;
      CELL_LOAD:       d = load_data;
      CELL_TAKE_LEFT:  d = from_left;
      CELL_TAKE_RIGHT: d = from_right;
      default:         d = q;
    endcase
  end

  // Item storage; contents are meaningless until first written.
  always_ff @(posedge clk) begin
    q <= d;
  end

endmodule

// ===== rtl/core/deqr_out_buf.sv =====
// ============================================================================
// deqr_out_buf: two-entry result buffer
// Output register plus one skid entry, so a new transaction can be taken
// while a finished result waits at the output.
// ============================================================================
module deqr_out_buf import deqr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      wr_en,
  input  deqr_rsp_t wr_data,
  output logic      full,
  output logic      rd_valid,
  output deqr_rsp_t rd_data,
  input  logic      rd_stall
);

  logic      valid0;
  logic      valid1;
  deqr_rsp_t slot0;
  deqr_rsp_t slot1;
  logic      take;

  assign take     = valid0 && !rd_stall;
  assign full     = valid1;
  assign rd_valid = valid0;
  assign rd_data  = slot0;

  // Occupancy flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid0 <= 1'b0;
      valid1 <= 1'b0;
    end else if (take) begin
      if (valid1) begin
        valid0 <= 1'b1;
        valid1 <= wr_en;
      end else begin
        valid0 <= wr_en;
      end
    end else if (wr_en) begin
      if (valid0) begin
        valid1 <= 1'b1;
      end else begin
        valid0 <= 1'b1;
      end
    end
  end

  // Payload entries; the skid entry moves up when the output is taken.
  always_ff @(posedge clk) begin
    if (take) begin
      if (valid1) begin
        slot0 <= slot1;
        if (wr_en) begin
          slot1 <= wr_data;
        end
      end else if (wr_en) begin
        slot0 <= wr_data;
      end
    end else if (wr_en) begin
      if (valid0) begin
        slot1 <= wr_data;
      end else begin
        slot0 <= wr_data;
      end
    end
  end

endmodule

// ===== rtl/core/double_ended_queue_ring_core.sv =====
// ============================================================================
// double_ended_queue_ring_core: bounded double-ended queue
// Push right, pop left, pop right and query commands on a queue of DEPTH
// items, one result transaction per command.
// ============================================================================
// The queue takes one command per clock cycle and delivers its result into a
// two-entry output buffer, so a command is accepted in every cycle unless two
// results are already waiting there; each command is done in the cycle it is accepted.
// Items live in two rows of DEPTH cells that hold the same contents: the left
// row keeps the left end in its first cell, the right row keeps the right end
// in its last cell, and cells shift toward or away from those ends, so both
// ends and the popped item are read from fixed cells. A pop on an empty queue
// or a push on a full one changes nothing and reports an error.
module double_ended_queue_ring_core import deqr_pkg::*; #(
  parameter int DEPTH      = 16,
  parameter int ITEM_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  deqr_req_t req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output deqr_rsp_t rsp
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int XW    = (ITEM_WIDTH > 32) ? ITEM_WIDTH : 32;

  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  logic [31:0]           count_ext;
  logic                  accept;
  logic                  is_full;
  logic                  is_empty;
  logic                  push_ok;
  logic                  pop_l_ok;
  logic                  pop_r_ok;
  logic                  refused;
  logic [XW-1:0]         in_ext;
  logic [ITEM_WIDTH-1:0] item_w;
  logic [ITEM_WIDTH-1:0] popped;
  logic [ITEM_WIDTH-1:0] left_w;
  logic [ITEM_WIDTH-1:0] right_w;
  logic [XW-1:0]         popped_ext;
  logic [XW-1:0]         left_ext;
  logic [XW-1:0]         right_ext;
  logic                  buf_full;
  deqr_rsp_t             result;
  deqr_cell_op_t         op_b;

  logic [ITEM_WIDTH-1:0] a_q [DEPTH];
  logic [ITEM_WIDTH-1:0] a_d [DEPTH];
  logic [ITEM_WIDTH-1:0] b_q [DEPTH];
  logic [ITEM_WIDTH-1:0] b_d [DEPTH];

  // Input handshake and command decode.
  assign req_stall = buf_full;
  assign accept    = req_valid && !req_stall;
  assign is_full   = (count == CNT_W'(DEPTH));
  assign is_empty  = (count == '0);
  assign push_ok   = accept && (req.command == CMD_PUSH_R) && !is_full;
  assign pop_l_ok  = accept && (req.command == CMD_POP_L) && !is_empty;
  assign pop_r_ok  = accept && (req.command == CMD_POP_R) && !is_empty;
  assign refused   = ((req.command == CMD_PUSH_R) && is_full) ||
                     (((req.command == CMD_POP_L) || (req.command == CMD_POP_R)) && is_empty);

  // Items are kept to ITEM_WIDTH bits.
  assign in_ext = XW'(req.item_in);
  assign item_w = in_ext[ITEM_WIDTH-1:0];

  // Item count.
  always_comb begin
    count_next = count;
    if (push_ok) begin
      count_next = count + CNT_W'(1);
    end else if (pop_l_ok || pop_r_ok) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // The right row moves as a whole: away from its last cell on a push, toward
  // it on a right pop. A left pop only shortens it at the far end.
  always_comb begin
    if (push_ok) begin
      op_b = CELL_TAKE_RIGHT;
    end else if (pop_r_ok) begin
      op_b = CELL_TAKE_LEFT;
    end else begin
      op_b = CELL_HOLD;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    deqr_cell_op_t         op_a;
    logic [ITEM_WIDTH-1:0] a_right;
    logic [ITEM_WIDTH-1:0] b_left;
    logic [ITEM_WIDTH-1:0] b_right;

    // Left row: a push lands in the cell just past the right end, a left
    // pop shifts every cell one place toward the first cell.
    always_comb begin
      if (push_ok && (count == CNT_W'(i))) begin
        op_a = CELL_LOAD;
      end else if (pop_l_ok) begin
        op_a = CELL_TAKE_RIGHT;
      end else begin
        op_a = CELL_HOLD;
      end
    end

    if (i == DEPTH - 1) begin : g_last
      assign a_right = '0;
      assign b_right = item_w;
    end else begin : g_mid
      assign a_right = a_q[i+1];
      assign b_right = b_q[i+1];
    end

    if (i == 0) begin : g_first
      assign b_left = '0;
    end else begin : g_rest
      assign b_left = b_q[i-1];
    end

    deqr_cell #(.W(ITEM_WIDTH)) u_cell_a (
      .clk        (clk),
      .op         (op_a),
      .load_data  (item_w),
      .from_left  ('0),
      .from_right (a_right),
      .q          (a_q[i]),
      .d          (a_d[i])
    );

    deqr_cell #(.W(ITEM_WIDTH)) u_cell_b (
      .clk        (clk),
      .op         (op_b),
      .load_data  (item_w),
      .from_left  (b_left),
      .from_right (b_right),
      .q          (b_q[i]),
      .d          (b_d[i])
    );
  end

  // Result of this command, taken from the end cells.
  always_comb begin
    if (pop_l_ok) begin
      popped = a_q[0];
    end else if (pop_r_ok) begin
      popped = b_q[DEPTH-1];
    end else begin
      popped = '0;
    end
  end

  assign left_w     = (count_next != '0) ? a_d[0] : '0;
  assign right_w    = (count_next != '0) ? b_d[DEPTH-1] : '0;
  assign popped_ext = XW'(popped);
  assign left_ext   = XW'(left_w);
  assign right_ext  = XW'(right_w);
  assign count_ext  = 32'(count_next);

  always_comb begin
    result.item_out   = popped_ext[31:0];
    result.left_item  = left_ext[31:0];
    result.right_item = right_ext[31:0];
    result.count      = count_ext[4:0];
    result.empty_res  = (count_next == '0);
    result.full_res   = (count_next == CNT_W'(DEPTH));
    result.error      = refused;
  end

  deqr_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (accept),
    .wr_data  (result),
    .full     (buf_full),
    .rd_valid (rsp_valid),
    .rd_data  (rsp),
    .rd_stall (rsp_stall)
  );

`ifndef NO_ASSERTIONS
  // The count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("item count above capacity");

  // A refused command leaves the count where it was.
  a_refused_stable: assert property (@(posedge clk) disable iff (rst)
    accept && refused |=> $stable(count))
    else $error("refused command changed the count");

  // With a single item held, both rows show the same item at their ends.
  a_rows_agree: assert property (@(posedge clk) disable iff (rst)
    count == CNT_W'(1) |-> a_q[0] == b_q[DEPTH-1])
    else $error("left and right rows disagree on the only item");

  // Input is only held off while a result waits at the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> rsp_valid)
    else $error("input stalled with no pending result");
`endif

endmodule
